>>> design/assert_macros.svh
// Assertion macros shared by the beat and intensity tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ABIT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("abit assertion failed");

// A condition in one cycle that implies another in the next cycle.
`define ABIT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("abit assertion failed");

`endif

>>> design/abit_pkg.sv
// Types and constants shared by the beat and intensity tracker modules.
`default_nettype none

package abit_pkg;

	localparam int AMP_W    = 24;
	localparam int SUM_W    = 26;
	localparam int VALUE_W  = 30;
	localparam int HIST_W   = 16;
	localparam int LEVEL_W  = 12;
	localparam int INTEN_W  = 16;
	localparam int BOOST_W  = 20;
	localparam int LNUM_W   = 17;
	localparam int SENS_W   = 15;
	localparam int CFG_W    = 16;
	localparam int DVD_W    = 37;
	localparam int DIV_W    = 31;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 56;

	localparam int BDIV_STEPS = 37;
	localparam int IDIV_STEPS = 16;

	localparam logic [SENS_W-1:0]  SENS_MAX  = 15'd25600;
	localparam logic [SENS_W-1:0]  SENS_RST  = 15'd12800;
	localparam logic [LNUM_W-1:0]  LNUM_BASE = 17'd80000;
	localparam logic [HIST_W-1:0]  ONE_Q12   = 16'd4096;
	localparam logic [LEVEL_W-1:0] BEAT_MAX  = 12'd2457;
	localparam logic [13:0]        RECIP5    = 14'd13108;

	localparam logic [0:0] REG_SENSITIVITY = 1'b0;
	localparam logic [0:0] REG_BOOST       = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_TEST,
		S_BSTART,
		S_BDIV,
		S_BEAT,
		S_DECAY,
		S_IDIV,
		S_BOOST,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic test;
		logic bstart;
		logic div_step;
		logic beat;
		logic decay;
		logic boost;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
	} status_t;

endpackage

`default_nettype wire

>>> design/abit_div.sv
// Restoring divider that produces one quotient bit per cycle while step is high.
`default_nettype none

module abit_div (
	input  wire                         clk,
	input  wire                         start,
	input  wire                         step,
	input  wire  [abit_pkg::DIV_W-1:0] rem_init,
	input  wire  [abit_pkg::DVD_W-1:0] dividend,
	input  wire  [abit_pkg::DIV_W-1:0] divisor,
	output logic [abit_pkg::DVD_W-1:0] quotient
);
	import abit_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DIV_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			div_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (step) begin
			rem_q <= ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> design/abit_ctrl.sv
// Sequencer that steps one item through scan, beat test, divisions and output.
`default_nettype none
`include "assert_macros.svh"

module abit_ctrl #(
	parameter int HISTORY_DEPTH = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire                     m_tready,
	input  wire abit_pkg::status_t  status,
	output abit_pkg::cmd_t          cmd
);
	import abit_pkg::*;

	localparam int CNT_MAX = (HISTORY_DEPTH > BDIV_STEPS) ? HISTORY_DEPTH : BDIV_STEPS;
	localparam int CW      = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

	state_t        state_q;
	state_t        state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;
	logic          cnt_zero;

	assign out_free = !out_valid_q || m_tready;
	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_tvalid) state_d = S_SCAN;
			S_SCAN:   if (cnt_zero) state_d = S_TEST;
			S_TEST:   state_d = S_BSTART;
			S_BSTART: state_d = status.hit ? S_BDIV : S_BEAT;
			S_BDIV:   if (cnt_zero) state_d = S_BEAT;
			S_BEAT:   state_d = S_DECAY;
			S_DECAY:  state_d = S_IDIV;
			S_IDIV:   if (cnt_zero) state_d = S_BOOST;
			S_BOOST:  state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_SCAN:   cmd.scan = 1'b1;
			S_TEST:   cmd.test = 1'b1;
			S_BSTART: cmd.bstart = 1'b1;
			S_BDIV:   cmd.div_step = 1'b1;
			S_BEAT:   cmd.beat = 1'b1;
			S_DECAY:  cmd.decay = 1'b1;
			S_IDIV:   cmd.div_step = 1'b1;
			S_BOOST:  cmd.boost = 1'b1;
			S_OUT:    cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				cnt_q <= CW'(HISTORY_DEPTH - 1);
			end else if (state_q == S_BSTART) begin
				cnt_q <= CW'(BDIV_STEPS - 1);
			end else if (state_q == S_DECAY) begin
				cnt_q <= CW'(IDIV_STEPS - 1);
			end else if (!cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	`ABIT_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n,
		(state_q == S_IDLE) && s_tvalid, state_q == S_SCAN)
	`ABIT_ASSERT(a_valid_rises_from_out, clk, arst_n,
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
	`ABIT_ASSERT_NEXT(a_bdiv_ends_in_beat, clk, arst_n,
		(state_q == S_BDIV) && cnt_zero, state_q == S_BEAT)

endmodule

`default_nettype wire

>>> design/abit_dp.sv
// Datapath: configuration, beat history, beat arithmetic, intensity and output word.
`default_nettype none
`include "assert_macros.svh"

module abit_dp #(
	parameter int HISTORY_DEPTH  = 8,
	parameter int WINDOW_SAMPLES = 512
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [0:0]                     cfg_index,
	input  wire  [abit_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire  [abit_pkg::S_DATA_W-1:0] s_tdata,
	output logic [abit_pkg::M_DATA_W-1:0] m_tdata,
	input  wire abit_pkg::cmd_t            cmd,
	output abit_pkg::status_t              status
);
	import abit_pkg::*;

	localparam logic [DIV_W-1:0] DEN_BASE = DIV_W'(12288 * WINDOW_SAMPLES);

	logic [SENS_W-1:0]  sens_q;
	logic [CFG_W-1:0]   boost_q;
	logic [LEVEL_W-1:0] store_q;
	logic [HIST_W-1:0]  hist_q [HISTORY_DEPTH];

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] num_q;
	logic [HIST_W-1:0]  min_q;
	logic [VALUE_W-1:0] excess_q;
	logic [LNUM_W-1:0]  lnum_q;
	logic               flag_q;
	logic [13:0]        tri_q;
	logic [INTEN_W-1:0] inten_q;
	logic [27:0]        bprod_q;

	logic [LEVEL_W-1:0] level_q;
	logic               beat_flag_q;
	logic [INTEN_W-1:0] intensity_q;
	logic [BOOST_W-1:0] boosted_q;

	logic [AMP_W-1:0]   amp_bin0;
	logic [AMP_W-1:0]   amp_bin1;
	logic [SUM_W-1:0]   abs_sum;
	logic [AMP_W:0]     amp_sum;
	logic [HIST_W-1:0]  tail;
	logic [SENS_W-1:0]  sens_c;
	logic [37:0]        lhs;
	logic [37:0]        rhs;
	logic [DVD_W-1:0]   bdvd;
	logic [DVD_W-1:0]   quotient;
	logic               div_start;
	logic [DIV_W-1:0]   div_rem;
	logic [DVD_W-1:0]   div_dvd;
	logic [DIV_W-1:0]   div_den;
	logic [HIST_W:0]    raw_sum;
	logic [HIST_W-1:0]  raw;
	logic [12:0]        clip;
	logic [27:0]        dprod;
	logic [24:0]        bsum;

	assign amp_bin0 = s_tdata[23:0];
	assign amp_bin1 = s_tdata[47:24];
	assign abs_sum  = s_tdata[73:48];
	assign amp_sum  = {1'b0, amp_bin0} + {1'b0, amp_bin1};
	assign tail     = hist_q[HISTORY_DEPTH-1];
	assign sens_c   = (sens_q > SENS_MAX) ? SENS_MAX : sens_q;

	assign lhs        = {1'b0, excess_q, 7'b0} + {3'b0, excess_q, 5'b0};
	assign rhs        = {9'b0, lnum_q, 12'b0};
	assign status.hit = (lhs > rhs);

	assign bdvd = {1'b0, excess_q, 6'b0} + {3'b0, excess_q, 4'b0};

	assign div_start = cmd.bstart || cmd.decay;
	assign div_rem   = cmd.decay ? {1'b0, num_q} : '0;
	assign div_dvd   = cmd.decay ? '0 : bdvd;
	assign div_den   = cmd.decay ? DIV_W'({1'b0, num_q} + DEN_BASE)
	                             : {{(DIV_W-LNUM_W){1'b0}}, lnum_q};

	abit_div u_div (
		.clk      (clk),
		.start    (div_start),
		.step     (cmd.div_step),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_den),
		.quotient (quotient)
	);

	assign raw_sum = {5'b0, store_q} + {1'b0, quotient[HIST_W-1:0]};
	always_comb begin
		if (!flag_q) begin
			raw = {4'b0, store_q};
		end else if ((|quotient[DVD_W-1:HIST_W]) || raw_sum[HIST_W]) begin
			raw = '1;
		end else begin
			raw = raw_sum[HIST_W-1:0];
		end
	end

	assign clip  = (raw > ONE_Q12) ? ONE_Q12[12:0] : raw[12:0];
	assign dprod = tri_q * RECIP5;
	assign bsum  = {9'b0, inten_q} + {1'b0, bprod_q[27:4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RST;
			boost_q <= '0;
			store_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SENSITIVITY: sens_q <= cfg_wdata[SENS_W-1:0];
					REG_BOOST:       boost_q <= cfg_wdata;
					default:         sens_q <= sens_q;
				endcase
			end
			if (cmd.scan) begin
				hist_q[0] <= tail;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end else if (cmd.beat) begin
				hist_q[0] <= raw;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
			if (cmd.decay) begin
				store_q <= dprod[27:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= {1'b0, amp_sum, 4'b0} + {2'b0, amp_sum, 3'b0};
			num_q   <= {1'b0, abs_sum, 3'b0} + {4'b0, abs_sum};
			min_q   <= '1;
		end
		if (cmd.scan && (tail < min_q)) begin
			min_q <= tail;
		end
		if (cmd.test) begin
			excess_q <= (value_q > {14'b0, min_q}) ? value_q - {14'b0, min_q} : '0;
			lnum_q   <= LNUM_BASE - ({1'b0, sens_c, 1'b0} + {2'b0, sens_c});
		end
		if (cmd.bstart) begin
			flag_q <= status.hit;
		end
		if (cmd.beat) begin
			tri_q <= {clip, 1'b0} + {1'b0, clip};
		end
		if (cmd.boost) begin
			inten_q <= (|quotient[DVD_W-1:INTEN_W]) ? '1 : quotient[INTEN_W-1:0];
			bprod_q <= store_q * boost_q;
		end
		if (cmd.out_load) begin
			level_q     <= store_q;
			beat_flag_q <= flag_q;
			intensity_q <= inten_q;
			boosted_q   <= (|bsum[24:20]) ? '1 : bsum[BOOST_W-1:0];
		end
	end

	assign m_tdata = {7'b0, boosted_q, intensity_q, beat_flag_q, level_q};

	`ABIT_ASSERT(a_store_in_range, clk, arst_n, store_q <= BEAT_MAX)
	`ABIT_ASSERT_NEXT(a_boost_not_below_intensity, clk, arst_n,
		cmd.out_load, boosted_q >= {4'b0, intensity_q})
	`ABIT_ASSERT_NEXT(a_no_beat_pushes_store, clk, arst_n,
		cmd.beat && !flag_q, hist_q[0] == {4'b0, $past(store_q)})

endmodule

`default_nettype wire

>>> design/audio_beat_intensity_tracker.sv
// Top level of the audio beat and intensity tracker.
//
//  Channel  Signals                            Contents
//  s        s_tvalid s_tready s_tdata[79:0]    one analysis step in
//  m        m_tvalid m_tready m_tdata[55:0]    one beat and intensity result out
//  cfg      cfg_we cfg_index cfg_wdata[15:0]   sensitivity and boost registers
//
// A step runs from acceptance through the history scan, the beat test, the beat
// division when a beat is found, the decay and the intensity division until the
// block is ready again. The history scan takes one entry per cycle and the shared
// divider gives one quotient bit per cycle (37 bits for the beat, 16 for intensity).
// A finished word waits in the output register while the next step is taken in;
// the next result waits for that register to be free. Reset clears the history,
// the beat level and the registers to their defaults at once.
`default_nettype none

module audio_beat_intensity_tracker #(
	parameter int HISTORY_DEPTH  = 8,
	parameter int WINDOW_SAMPLES = 512
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// amp_bin0[23:0], amp_bin1[47:24], abs_sum[73:48], zero fill
	input  wire  [79:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// beat_level[11:0], beat_flag[12], intensity_level[28:13],
	// boosted_intensity[48:29], zero fill
	output logic [55:0] m_tdata,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_wdata
);
	import abit_pkg::*;

	cmd_t    cmd;
	status_t status;

	abit_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	abit_dp #(
		.HISTORY_DEPTH  (HISTORY_DEPTH),
		.WINDOW_SAMPLES (WINDOW_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire
